// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the LLR descrambler.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, reset-qualified.
`define GSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("descrambler check failed");
// Next-cycle implication, reset-qualified.
`define GSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("descrambler check failed");
`else
`define GSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GSD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/gsd_pkg.sv
// Types, constants and LFSR functions of the Gold-sequence LLR descrambler.
// No dependencies.
package gsd_pkg;

    localparam int SeqLen      = 31;
    localparam int WarmupSteps = 1600;
    localparam int LlrW        = 16;
    localparam int CfgDataW    = 16;
    localparam int CfgAddrW    = 2;

    typedef logic [SeqLen-1:0]              t_seq;
    typedef logic [SeqLen-1:0][SeqLen-1:0]  t_mat;
    typedef logic signed [LlrW-1:0]         t_llr;
    typedef logic [CfgAddrW-1:0]            t_cfg_addr;
    typedef logic [CfgDataW-1:0]            t_cfg_data;

    localparam t_cfg_addr CfgRnti  = 2'd0;
    localparam t_cfg_addr CfgCw    = 2'd1;
    localparam t_cfg_addr CfgScid  = 2'd2;

    localparam t_llr LlrMin = {1'b1, {(LlrW-1){1'b0}}};
    localparam t_llr LlrMax = {1'b0, {(LlrW-1){1'b1}}};

    // Core status seen by the top-level checks
    typedef struct packed {
        logic in_vld;
        logic out_vld;
        logic move;
        logic restart_taken;
        t_seq x1;
    } t_core_stat;

    // x1(n+31) = x1(n+3) ^ x1(n)
    function automatic t_seq gsd_adv1(t_seq a);
        return {a[0] ^ a[3], a[SeqLen-1:1]};
    endfunction

    // x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n)
    function automatic t_seq gsd_adv2(t_seq b);
        return {b[0] ^ b[1] ^ b[2] ^ b[3], b[SeqLen-1:1]};
    endfunction

    // x1 after warm-up from the fixed seed 1 (elaboration only)
    function automatic t_seq gsd_x1_warm_calc();
        t_seq v;
        v = t_seq'(1);
        for (int n = 0; n < WarmupSteps; n++) v = gsd_adv1(v);
        return v;
    endfunction

    // Column j: warm-up image of unit seed bit j (elaboration only)
    function automatic t_mat gsd_x2_cols_calc();
        t_mat m;
        t_seq v;
        for (int j = 0; j < SeqLen; j++) begin
            v = t_seq'(1) << j;
            for (int n = 0; n < WarmupSteps; n++) v = gsd_adv2(v);
            m[j] = v;
        end
        return m;
    endfunction

    localparam t_seq X1Warm = gsd_x1_warm_calc();
    localparam t_mat X2Cols = gsd_x2_cols_calc();

    // Warm-up is linear over GF(2): XOR of the columns picked by the seed
    function automatic t_seq gsd_x2_warm(t_seq seed);
        t_seq acc;
        acc = '0;
        for (int j = 0; j < SeqLen; j++) begin
            if (seed[j]) acc = acc ^ X2Cols[j];
        end
        return acc;
    endfunction

endpackage

// File: rtl/gsd_llr_in_if.sv
// Input request channel: one soft bit and a restart flag.
// Depends on gsd_pkg.
interface gsd_llr_in_if;
    import gsd_pkg::*;

    logic valid;
    logic ready;
    t_llr llr_in;
    logic restart;

    modport source (output valid, output llr_in, output restart, input ready);
    modport sink   (input valid, input llr_in, input restart, output ready);
endinterface

// File: rtl/gsd_llr_out_if.sv
// Output request channel: one descrambled soft bit.
// Depends on gsd_pkg.
interface gsd_llr_out_if;
    import gsd_pkg::*;

    logic valid;
    logic ready;
    t_llr llr_out;

    modport source (output valid, output llr_out, input ready);
    modport sink   (input valid, input llr_out, output ready);
endinterface

// File: rtl/gsd_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on gsd_pkg.
interface gsd_cfg_if;
    import gsd_pkg::*;

    logic      valid;
    logic      ready;
    t_cfg_addr index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/gold_sequence_llr_descrambler.sv
// Gold-sequence LLR descrambler, top level: configuration block plus datapath.
// Depends on gsd_pkg, the three channel interfaces, gsd_cfg, gsd_core and assert_macros.svh.
//
// Streams signed 16-bit soft bits (LLRs) in scrambling order and flips the sign of each one
// whose NR Gold sequence bit c(n) = x1(n) ^ x2(n) is 1; -32768 flipped saturates to 32767.
// Throughput is one request per clock while the receiver keeps ready high. An accepted
// request sits in the input register and moves into the result register once that is
// empty or being read; a stalled receiver leaves it waiting in the input register. A request
// with restart set reseeds both LFSRs before it is descrambled: x1 from 1, x2 from c_init =
// rnti<<15 | codeword<<14 | scrambling_id, each advanced 1600 steps. The warm-up is not
// stepped at run time: it is a fixed GF(2) matrix, applied to the seed when a configuration
// register is written and held ready in a register, and a constant for x1. Config writes
// (index 0 rnti, 1 codeword, 2 scrambling id, others ignored) are accepted every cycle and
// must happen while the block is idle; they take effect at the next restart. Until the first
// restart after reset the sequence is all zeros and LLRs pass through unchanged. The sequence
// keeps running across requests until the next restart.
`include "assert_macros.svh"

module gold_sequence_llr_descrambler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gsd_cfg_if.sink       i_cfg,
    gsd_llr_in_if.sink    i_llr,
    gsd_llr_out_if.source o_llr
);
    import gsd_pkg::*;

    t_seq       w_x2_warm;
    t_core_stat w_stat;

    // Register file; holds the x2 seed already warmed up
    gsd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_x2_warm (w_x2_warm)
    );

    // Single-pass datapath between input and result registers
    gsd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_x2_warm (w_x2_warm),
        .i_llr     (i_llr),
        .o_llr     (o_llr),
        .o_stat    (w_stat)
    );

    // Backpressure only when both stages hold a request
    `GSD_ASSERT_IMP(a_ready_full, i_clk, i_rst_n, !i_llr.ready, w_stat.in_vld && w_stat.out_vld)
    // A result appears only after a request sat in the input stage
    `GSD_ASSERT_IMP(a_out_from_in, i_clk, i_rst_n, $rose(w_stat.out_vld), $past(w_stat.in_vld))
    // Restart lands x1 one step past its warm-up value
    `GSD_ASSERT_NXT(a_x1_reseed, i_clk, i_rst_n, w_stat.restart_taken,
                    w_stat.x1 == gsd_adv1(X1Warm))
endmodule

// File: rtl/gsd_cfg.sv
// Configuration registers and the precomputed warm x2 seed.
// Depends on gsd_pkg and gsd_cfg_if.
module gsd_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gsd_cfg_if.sink        i_cfg,
    output gsd_pkg::t_seq  o_x2_warm
);
    import gsd_pkg::*;

    logic [15:0] r_rnti, n_rnti;
    logic        r_cw, n_cw;
    logic [9:0]  r_scid, n_scid;
    t_seq        r_x2_warm, n_x2_warm;
    logic        w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    always_comb begin
        n_rnti = r_rnti;
        n_cw   = r_cw;
        n_scid = r_scid;
        unique case (i_cfg.index)
            CfgRnti: n_rnti = i_cfg.data[15:0];
            CfgCw:   n_cw   = i_cfg.data[0];
            CfgScid: n_scid = i_cfg.data[9:0];
            default: ;
        endcase
        // seed bits 13..10 are zero
        n_x2_warm = gsd_x2_warm({n_rnti, n_cw, 4'b0000, n_scid});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnti    <= '0;
            r_cw      <= 1'b0;
            r_scid    <= '0;
            r_x2_warm <= '0;
        end else if (w_wr) begin
            r_rnti    <= n_rnti;
            r_cw      <= n_cw;
            r_scid    <= n_scid;
            r_x2_warm <= n_x2_warm;
        end
    end

    assign o_x2_warm = r_x2_warm;
endmodule

// File: rtl/gsd_core.sv
// Datapath: input register, Gold LFSRs, sign flip with saturation, output register.
// Depends on gsd_pkg, gsd_llr_in_if and gsd_llr_out_if.
module gsd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gsd_pkg::t_seq       i_x2_warm,
    gsd_llr_in_if.sink          i_llr,
    gsd_llr_out_if.source       o_llr,
    output gsd_pkg::t_core_stat o_stat
);
    import gsd_pkg::*;

    logic r_in_vld, n_in_vld;
    logic r_out_vld, n_out_vld;
    t_llr r_in_llr;
    logic r_in_rst;
    t_llr r_out_llr, n_out_llr;
    t_seq r_x1, n_x1;
    t_seq r_x2, n_x2;
    t_seq w_cur1, w_cur2;
    t_llr w_neg;
    logic w_bit, w_move, w_acc;

    always_comb begin
        w_move      = r_in_vld && (!r_out_vld || o_llr.ready);
        i_llr.ready = !r_in_vld || w_move;
        w_acc       = i_llr.valid && i_llr.ready;
        n_in_vld    = w_acc || (r_in_vld && !w_move);
        n_out_vld   = w_move || (r_out_vld && !o_llr.ready);

        w_cur1 = r_in_rst ? X1Warm    : r_x1;
        w_cur2 = r_in_rst ? i_x2_warm : r_x2;
        w_bit  = w_cur1[0] ^ w_cur2[0];
        n_x1   = gsd_adv1(w_cur1);
        n_x2   = gsd_adv2(w_cur2);

        w_neg     = (r_in_llr == LlrMin) ? LlrMax : -r_in_llr;
        n_out_llr = w_bit ? w_neg : r_in_llr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_x1      <= '0;
            r_x2      <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (w_move) begin
                r_x1 <= n_x1;
                r_x2 <= n_x2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in_llr <= i_llr.llr_in;
            r_in_rst <= i_llr.restart;
        end
        if (w_move) r_out_llr <= n_out_llr;
    end

    assign o_llr.valid   = r_out_vld;
    assign o_llr.llr_out = r_out_llr;

    assign o_stat.in_vld        = r_in_vld;
    assign o_stat.out_vld       = r_out_vld;
    assign o_stat.move          = w_move;
    assign o_stat.restart_taken = w_move && r_in_rst;
    assign o_stat.x1            = r_x1;
endmodule

// File: tb/testbench.sv
// Self-checking bench for the Gold-sequence LLR descrambler.
// Depends on gsd_pkg, the three channel interfaces and the descrambler top level.
// A directed table, then phases of random slot-like streams, checked by an in-bench predictor.
module testbench;
    import gsd_pkg::*;

    localparam int NumRows       = 26;
    localparam int NumPhases     = 6;
    localparam int PhaseItems    = 95;
    localparam int LongStall     = 300;   // receiver hold-off that fills the pipe
    localparam int TailCycles    = 6;     // margin after the last result is back
    localparam int WatchdogLimit = 2000;  // cycles with no request moving on any channel

    localparam t_cfg_addr CfgUnused = 2'd3;  // no register behind this index

    typedef enum logic {RowLlr, RowCfg} row_kind_e;

    // One row of the directed table: either a config write or one soft bit.
    typedef struct packed {
        row_kind_e kind;
        t_cfg_addr idx;
        t_cfg_data data;
        t_llr      llr;
        logic      restart;
        logic      fixed_vld;  // expected value typed in below
        t_llr      fixed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    gsd_cfg_if     cfg_ch ();
    gsd_llr_in_if  in_ch ();
    gsd_llr_out_if out_ch ();

    gold_sequence_llr_descrambler dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cfg  (cfg_ch),
        .i_llr  (in_ch),
        .o_llr  (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Directed table. Before any restart the sequence is all zeros, so LLRs pass through;
    // register writes stay dormant until the next restart; zero negated is zero.
    stim_row_t dir_rows [NumRows] = '{
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b0, 1'b1, LlrMin},
        '{RowLlr, CfgRnti,   16'h0000, LlrMax,      1'b0, 1'b1, LlrMax},
        '{RowLlr, CfgRnti,   16'h0000, 16'sh0000,   1'b0, 1'b1, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, 16'shFFFF,   1'b0, 1'b1, 16'shFFFF},
        '{RowLlr, CfgRnti,   16'h0000, 16'sh0001,   1'b0, 1'b1, 16'sh0001},
        '{RowCfg, CfgRnti,   16'hFFFF, 16'sh0000,   1'b0, 1'b0, 16'sh0000},
        '{RowCfg, CfgCw,     16'hFFFF, 16'sh0000,   1'b0, 1'b0, 16'sh0000},
        '{RowCfg, CfgScid,   16'hFFFF, 16'sh0000,   1'b0, 1'b0, 16'sh0000},
        '{RowCfg, CfgUnused, 16'h5555, 16'sh0000,   1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, 16'sh1234,   1'b0, 1'b1, 16'sh1234},
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b1, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMax,      1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, 16'sh0000,   1'b0, 1'b1, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, 16'shFFFF,   1'b0, 1'b0, 16'sh0000},
        '{RowCfg, CfgRnti,   16'h0000, 16'sh0000,   1'b0, 1'b0, 16'sh0000},
        '{RowCfg, CfgCw,     16'h0000, 16'sh0000,   1'b0, 1'b0, 16'sh0000},
        '{RowCfg, CfgScid,   16'h0000, 16'sh0000,   1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b1, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMax,      1'b0, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, LlrMin,      1'b1, 1'b0, 16'sh0000},
        '{RowLlr, CfgRnti,   16'h0000, 16'sh5A5A,   1'b1, 1'b0, 16'sh0000}
    };

    // ---------------------------------------------------------------------------------
    // Predictor: own copy of the registers and of both LFSRs
    // ---------------------------------------------------------------------------------
    logic [15:0]       cfg_rnti;
    logic              cfg_cw;
    logic [9:0]        cfg_scid;
    logic [SeqLen-1:0] gold_x1;
    logic [SeqLen-1:0] gold_x2;
    t_llr              llr_expected [$];
    int                mismatches = 0;

    // Side band carried along with each input request of the directed table
    logic              drv_fixed_vld;
    t_llr              drv_fixed;

    // Control between the sender and the receiver processes
    bit                stall_req = 1'b0;
    bit                quiet     = 1'b0;

    logic              seq_bit;
    t_llr              want;

    // One step of both generators; the new bit enters at the top.
    function automatic void gold_advance();
        gold_x1 = {gold_x1[0] ^ gold_x1[3], gold_x1[SeqLen-1:1]};
        gold_x2 = {gold_x2[0] ^ gold_x2[1] ^ gold_x2[2] ^ gold_x2[3], gold_x2[SeqLen-1:1]};
    endfunction

    // Sign flip with saturation: the most negative value maps to the most positive.
    function automatic t_llr descramble_llr(t_llr v, logic flip);
        if (!flip) return v;
        if (v == LlrMin) return LlrMax;
        return -v;
    endfunction

    wire in_acc  = in_ch.valid  && in_ch.ready;
    wire out_acc = out_ch.valid && out_ch.ready;
    wire cfg_acc = cfg_ch.valid && cfg_ch.ready;

    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_rnti = '0;
            cfg_cw   = 1'b0;
            cfg_scid = '0;
            gold_x1  = '0;
            gold_x2  = '0;
        end else begin
            // Results first: the oldest expectation belongs to the oldest request.
            if (out_acc) begin
                if (llr_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected llr_out, expected none, actual %0d",
                             $time, out_ch.llr_out);
                end else begin
                    want = llr_expected.pop_front();
                    if (out_ch.llr_out !== want) begin
                        mismatches++;
                        $display("%0t: llr_out mismatch, expected %0d, actual %0d",
                                 $time, want, out_ch.llr_out);
                    end
                end
            end
            if (cfg_acc) begin
                case (cfg_ch.index)
                    CfgRnti: cfg_rnti = cfg_ch.data[15:0];
                    CfgCw:   cfg_cw   = cfg_ch.data[0];
                    CfgScid: cfg_scid = cfg_ch.data[9:0];
                    default: ;  // unknown index: dropped
                endcase
            end
            if (in_acc) begin
                // Restart: reseed x1 from 1 and x2 from c_init, then 1600 warm-up steps
                if (in_ch.restart) begin
                    gold_x1 = SeqLen'(1);
                    gold_x2 = {cfg_rnti, cfg_cw, 4'b0000, cfg_scid};
                    for (int n = 0; n < WarmupSteps; n++) gold_advance();
                end
                seq_bit = gold_x1[0] ^ gold_x2[0];
                gold_advance();
                if (drv_fixed_vld) llr_expected.push_back(drv_fixed);
                else llr_expected.push_back(descramble_llr(in_ch.llr_in, seq_bit));
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Watchdog: no request moving on any channel for too long ends the run
    // ---------------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || in_acc || out_acc || cfg_acc) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Receiver: random ready bursts, one long hold-off on request, none when quiet
    // ---------------------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (stall_req) begin
                out_ch.ready <= 1'b0;
                repeat (LongStall) @(posedge clk);
                stall_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Sender tasks
    // ---------------------------------------------------------------------------------

    // Offer one soft bit, optionally after an idle burst, and wait for it to be taken.
    task automatic send_llr(t_llr llr, logic restart, logic fixed_vld, t_llr fixed,
                            bit gappy);
        int gap;
        gap = 0;
        if (gappy && !quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.llr_in  <= llr;
        in_ch.restart <= restart;
        drv_fixed_vld <= fixed_vld;
        drv_fixed     <= fixed;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every result is back, then TailCycles more.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (llr_expected.size() != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);
    endtask

    // Config write; valid drops for a cycle after each request.
    task automatic write_reg(t_cfg_addr idx, t_cfg_data value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Extremes weighted up, the rest uniform over all 16 bits.
    function automatic t_llr pick_llr();
        case ($urandom_range(0, 7))
            0:       return LlrMin;
            1:       return LlrMax;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return t_llr'($urandom_range(0, 65535));
        endcase
    endfunction

    // ---------------------------------------------------------------------------------
    // Main stimulus
    // ---------------------------------------------------------------------------------
    initial begin
        int  phase_cnt;
        int  run_len;
        bit  gappy;
        bit  lead;

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.llr_in  <= '0;
        in_ch.restart <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CfgRnti;
        cfg_ch.data   <= '0;
        drv_fixed_vld <= 1'b0;
        drv_fixed     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; config rows only once the pipe is empty
        for (int r = 0; r < NumRows; r++) begin
            if (dir_rows[r].kind == RowCfg) begin
                wait_drained();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                send_llr(dir_rows[r].llr, dir_rows[r].restart, dir_rows[r].fixed_vld,
                         dir_rows[r].fixed, bit'($urandom_range(0, 1)));
            end
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < NumPhases; ph++) begin
            wait_drained();
            drv_fixed_vld <= 1'b0;
            case (ph)
                0: begin  // all seed fields at their maximum
                    write_reg(CfgRnti, 16'hFFFF);
                    write_reg(CfgCw,   16'h0001);
                    write_reg(CfgScid, 16'h03FF);
                end
                1: begin  // all-zero seed: x2 stays zero
                    write_reg(CfgScid, 16'h0000);
                    write_reg(CfgCw,   16'h0000);
                    write_reg(CfgRnti, 16'h0000);
                end
                default: begin
                    write_reg(CfgRnti, t_cfg_data'($urandom_range(0, 65535)));
                    write_reg(CfgCw,   t_cfg_data'($urandom_range(0, 65535)));
                    write_reg(CfgScid, t_cfg_data'($urandom_range(0, 65535)));
                end
            endcase
            if (ph % 2 == 1) write_reg(CfgUnused, t_cfg_data'($urandom_range(0, 65535)));
            quiet = (ph == NumPhases - 1);
            phase_cnt = 0;

            // Long receiver hold-off while requests keep coming back to back
            if (ph == 2) begin
                stall_req = 1'b1;
                for (int k = 0; k < 30; k++) begin
                    send_llr(pick_llr(), 1'b0, 1'b0, '0, 1'b0);
                end
                phase_cnt += 30;
            end

            while (phase_cnt < PhaseItems) begin
                gappy = ($urandom_range(0, 2) != 0);
                if ($urandom_range(0, 99) < 85) begin
                    // Slot: restart, then a run on the same sequence. The first slot of a
                    // phase sometimes skips the restart to run on the old sequence.
                    lead    = !(phase_cnt == 0 && $urandom_range(0, 3) == 0);
                    run_len = $urandom_range(1, 30);
                    for (int k = 0; k <= run_len; k++) begin
                        send_llr(pick_llr(), (k == 0) && lead, 1'b0, '0, gappy);
                    end
                    phase_cnt += run_len + 1;
                end else begin
                    // Noise: restart at random points
                    run_len = $urandom_range(1, 5);
                    for (int k = 0; k < run_len; k++) begin
                        send_llr(pick_llr(), logic'($urandom_range(0, 1)), 1'b0, '0, gappy);
                    end
                    phase_cnt += run_len;
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
